FILE: src/it214_pkg.sv
// Shared types and constants for the IT214 sample decompressor.
// Used by it214_front, it214_back and the top level; no dependencies.
package it214_pkg;

  // Code widths and width-field sizes for the two sample formats.
  localparam logic [4:0] FullW8   = 5'd9;
  localparam logic [4:0] FullW16  = 5'd17;
  localparam logic [2:0] FieldW8  = 3'd3;
  localparam logic [2:0] FieldW16 = 3'd4;

  // Middle-width border offsets and spans.
  localparam logic [16:0] BorderOfs8  = 17'd4;
  localparam logic [16:0] BorderOfs16 = 17'd8;
  localparam logic [16:0] Span8       = 17'd8;
  localparam logic [16:0] Span16      = 17'd16;

  // Codes below this width use the marker plus width-field scheme.
  localparam logic [4:0] SmallWidthLimit = 5'd7;

  // Most samples that one compressed byte may produce.
  localparam logic [3:0] MaxSamplesPerByte = 4'd8;

  localparam int unsigned ValueW = 16;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_BYTE  = 1'b1
  } item_kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_DECODE
  } back_state_e;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    item_kind_e        kind;
    logic [ValueW-1:0] value;  // clamped sample count or compressed byte
  } item_t;

endpackage

FILE: src/it214_sample_decompressor.sv
// IT214 sample decompressor: a byte item is written into the front queue, from which the
// decoder takes it when idle; it then decodes one code per cycle from the bit buffer while the
// output stage is free or being read. A byte decodes at most 8 samples plus width changes;
// a start item loads the block count and resets the decoder state without decoding.
// The queue holds two items, so input is accepted while the decoder works, until the queue is full.
// Reset (rst_ni low, asynchronous) empties the queue, clears the state and sets width 9.
module it214_sample_decompressor import it214_pkg::*; #(
  parameter int unsigned MAX_BLOCK_SAMPLES = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,        // sixteen_bit_mode
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,     // [15:0] block_samples, [23:16] data_byte
  input  logic        s_axis_tuser_i,     // mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,     // [15:0] sample
  output logic        m_axis_tlast_o      // block_done
);

  logic  sixteen_bit_mode_q;
  logic  q_valid, q_ready;
  item_t q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sixteen_bit_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      sixteen_bit_mode_q <= cfg_wdata_i;
    end
  end

  it214_front #(
    .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid_i),
    .in_ready_o        (s_axis_tready_o),
    .in_mode_i         (s_axis_tuser_i),
    .in_block_samples_i(s_axis_tdata_i[15:0]),
    .in_data_byte_i    (s_axis_tdata_i[23:16]),
    .out_valid_o       (q_valid),
    .out_ready_i       (q_ready),
    .out_item_o        (q_item)
  );

  it214_back #(
    .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wide_i          (sixteen_bit_mode_q),
    .in_valid_i      (q_valid),
    .in_ready_o      (q_ready),
    .in_item_i       (q_item),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_sample_o    (m_axis_tdata_o),
    .out_block_done_o(m_axis_tlast_o)
  );

endmodule

FILE: src/it214_front.sv
// Front end: accepts stream items, classifies them and clamps the block count.
// Holds a two-entry queue toward the decoder. Depends on it214_pkg.
module it214_front import it214_pkg::*; #(
  parameter int unsigned MAX_BLOCK_SAMPLES = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_mode_i,
  input  logic [15:0] in_block_samples_i,
  input  logic [7:0]  in_data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output item_t       out_item_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;
  item_t            new_item;

  always_comb begin
    if (in_mode_i == KIND_START) begin
      new_item.kind = KIND_START;
      if (in_block_samples_i > 16'(MAX_BLOCK_SAMPLES)) begin
        new_item.value = 16'(MAX_BLOCK_SAMPLES);
      end else begin
        new_item.value = in_block_samples_i;
      end
    end else begin
      new_item.kind  = KIND_BYTE;
      new_item.value = {8'h00, in_data_byte_i};
    end
  end

  assign in_ready_o  = (cnt_q != CntW'(Depth));
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("front queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> cnt_q != '0)
    else $error("front queue popped while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push && !pop) |=> cnt_q == CntW'($past(cnt_q) + 1'b1))
    else $error("front queue count missed a push");

endmodule

FILE: src/it214_back.sv
// Back end: bit buffer, code-width tracking and delta accumulation. Depends on it214_pkg.
// One code per cycle to a registered output, paused while a sample waits unread.
module it214_back import it214_pkg::*; #(
  parameter int unsigned MAX_BLOCK_SAMPLES = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wide_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  item_t       in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_sample_o,
  output logic        out_block_done_o
);

  localparam int unsigned CntW = $clog2(MAX_BLOCK_SAMPLES + 1);

  back_state_e      state_q, state_d;
  logic [31:0]      buf_q, buf_d;
  logic [5:0]       held_q, held_d;
  logic [4:0]       cw_q, cw_d;
  logic             pend_q, pend_d;
  logic [15:0]      acc_q, acc_d;
  logic [CntW-1:0]  left_q, left_d;
  logic [3:0]       n_q, n_d;
  logic             ov_q, ov_d;
  logic [15:0]      osample_q, osample_d;
  logic             olast_q, olast_d;

  logic [4:0]  full;
  logic [2:0]  field_w;
  logic [31:0] mask;
  logic [16:0] v, top, border, span, sext_mask;
  logic [15:0] sext, acc_sum, acc_next;
  logic [4:0]  nw_field, nw_mid;
  logic [7:0]  nw_full;
  logic [3:0]  field_v;
  logic        sign, step_ok, in_mid_range;
  logic [4:0]  cw_clamped;

  always_comb begin
    full     = wide_i ? FullW16 : FullW8;
    field_w  = wide_i ? FieldW16 : FieldW8;
    mask     = ~(32'hFFFF_FFFF << cw_q);
    v        = buf_q[16:0] & mask[16:0];
    top      = 17'd1 << (cw_q - 5'd1);
    sign     = (v & top) != '0;
    border   = (top - 17'd1) - (wide_i ? BorderOfs16 : BorderOfs8);
    span     = wide_i ? Span16 : Span8;
    in_mid_range = (v > border) && (v <= border + span);
    nw_mid   = 5'(v - border);
    if (nw_mid >= cw_q) begin
      nw_mid = nw_mid + 5'd1;
    end
    field_v  = wide_i ? buf_q[3:0] : {1'b0, buf_q[2:0]};
    nw_field = {1'b0, field_v} + 5'd1;
    if (nw_field >= cw_q) begin
      nw_field = nw_field + 5'd1;
    end
    nw_full   = v[7:0] + 8'd1;
    sext_mask = sign ? ~mask[16:0] : '0;
    sext      = v[15:0] | sext_mask[15:0];
    acc_sum   = acc_q + sext;
    acc_next  = wide_i ? acc_sum : {8'h00, acc_sum[7:0]};
    cw_clamped = (cw_q > full || cw_q == '0) ? full : cw_q;
  end

  assign step_ok = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    buf_d     = buf_q;
    held_d    = held_q;
    cw_d      = cw_q;
    pend_d    = pend_q;
    acc_d     = acc_q;
    left_d    = left_q;
    n_d       = n_q;
    ov_d      = ov_q && !out_ready_i;
    osample_d = osample_q;
    olast_d   = olast_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.kind == KIND_START) begin
            buf_d  = '0;
            held_d = '0;
            cw_d   = full;
            pend_d = 1'b0;
            acc_d  = '0;
            left_d = in_item_i.value[CntW-1:0];
          end else if (left_q != '0) begin
            cw_d    = cw_clamped;
            buf_d   = buf_q | ({24'h000000, in_item_i.value[7:0]} << held_q);
            held_d  = held_q + 6'd8;
            n_d     = '0;
            state_d = ST_DECODE;
          end
        end
      end
      ST_DECODE: begin
        if (left_q == '0 || n_q == MaxSamplesPerByte) begin
          state_d = ST_IDLE;
        end else if (pend_q) begin
          if (held_q < {3'b000, field_w}) begin
            state_d = ST_IDLE;
          end else begin
            buf_d  = buf_q >> field_w;
            held_d = held_q - {3'b000, field_w};
            cw_d   = nw_field;
            pend_d = 1'b0;
          end
        end else if (held_q < {1'b0, cw_q}) begin
          state_d = ST_IDLE;
        end else if (step_ok) begin
          buf_d  = buf_q >> cw_q;
          held_d = held_q - {1'b0, cw_q};
          priority if (cw_q < SmallWidthLimit && v == top) begin
            pend_d = 1'b1;
          end else if (cw_q >= SmallWidthLimit && cw_q < full && in_mid_range) begin
            cw_d = nw_mid;
          end else if (cw_q >= full && sign) begin
            // A full-width change to zero or past the full width is dropped.
            if (nw_full != 8'd0 && nw_full <= {3'b000, full}) begin
              cw_d = nw_full[4:0];
            end
          end else begin
            acc_d     = acc_next;
            left_d    = left_q - 1'b1;
            n_d       = n_q + 4'd1;
            ov_d      = 1'b1;
            osample_d = wide_i ? acc_next : {acc_next[7:0], 8'h00};
            olast_d   = (left_q == CntW'(1));
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      buf_q   <= '0;
      held_q  <= '0;
      cw_q    <= FullW8;
      pend_q  <= 1'b0;
      acc_q   <= '0;
      left_q  <= '0;
      n_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      buf_q   <= buf_d;
      held_q  <= held_d;
      cw_q    <= cw_d;
      pend_q  <= pend_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      n_q     <= n_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    osample_q <= osample_d;
    olast_q   <= olast_d;
  end

  assign out_valid_o      = ov_q;
  assign out_sample_o     = osample_q;
  assign out_block_done_o = olast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q <= 6'd24)
    else $error("bit buffer holds more bits than a byte can leave");
  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= MaxSamplesPerByte)
    else $error("too many samples for one byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cw_q != '0)
    else $error("code width became zero");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(ov_q) |-> $past(state_q == ST_DECODE))
    else $error("sample produced outside decoding");

endmodule
